[rtl/pcor_pkg.sv]
`default_nettype none
package pcor_pkg;
	localparam int MAX_BALLS_DEF = 64;
	localparam int POS_W = 24;
	localparam int RAD_W = 16;
	localparam int FAC_W = 16;
	localparam logic [FAC_W-1:0] FACTOR_RESET = 16'h8000;
	localparam int SQ_W = 50;
	localparam int ROOT_W = 25;
	localparam int NUM_W = 66;
	localparam int DEN_W = 41;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_PAIR_INIT,
		ST_RD_I,
		ST_RD_J,
		ST_SQUARE,
		ST_SQRT,
		ST_CHECK,
		ST_PROD,
		ST_DIV,
		ST_WB_I,
		ST_WB_J,
		ST_EMIT_RD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic store_in;
		logic clr_total;
		logic pair_init;
		logic rd_i;
		logic rd_j;
		logic square;
		logic sqrt_start;
		logic prod;
		logic div_start;
		logic wb_i;
		logic wb_j;
		logic next_pair;
		logic emit_rd;
		logic out_load;
		logic emit_next;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic pair_done;
		logic sqrt_done;
		logic div_done;
		logic do_push;
		logic emit_done;
	} sts_t;
endpackage
`default_nettype wire

[rtl/pcor_if.sv]
`default_nettype none
interface pcor_in_if;
	logic valid;
	logic ready;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_y;
	logic [15:0] radius;
	logic last_ball;
	modport source(output valid, pos_x, pos_y, radius, last_ball, input ready);
	modport sink(input valid, pos_x, pos_y, radius, last_ball, output ready);
endinterface

interface pcor_out_if;
	logic valid;
	logic ready;
	logic signed [23:0] new_x;
	logic signed [23:0] new_y;
	logic last_out;
	modport source(output valid, new_x, new_y, last_out, input ready);
	modport sink(input valid, new_x, new_y, last_out, output ready);
endinterface

interface pcor_cfg_if;
	logic valid;
	logic ready;
	logic [15:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/pcor_ctrl.sv]
`default_nettype none
module pcor_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_fire,
	input  wire logic in_last,
	input  wire logic out_fire,
	input  wire logic out_valid,
	input  wire pcor_pkg::sts_t sts,
	output pcor_pkg::cmd_t cmd,
	output logic in_ready
);
	import pcor_pkg::*;
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: if (in_fire && in_last) state_d = ST_PAIR_INIT;
			ST_PAIR_INIT: state_d = sts.pair_done ? ST_EMIT_RD : ST_RD_I;
			ST_RD_I: state_d = ST_RD_J;
			ST_RD_J: state_d = ST_SQUARE;
			ST_SQUARE: state_d = ST_SQRT;
			ST_SQRT: if (sts.sqrt_done) state_d = ST_CHECK;
			ST_CHECK: state_d = sts.do_push ? ST_PROD
				: (sts.pair_done ? ST_EMIT_RD : ST_RD_I);
			ST_PROD: state_d = ST_DIV;
			ST_DIV: if (sts.div_done) state_d = ST_WB_I;
			ST_WB_I: state_d = ST_WB_J;
			ST_WB_J: state_d = sts.pair_done ? ST_EMIT_RD : ST_RD_I;
			ST_EMIT_RD: if (!out_valid || out_fire) state_d = ST_EMIT;
			ST_EMIT: state_d = sts.emit_done ? ST_LOAD : ST_EMIT_RD;
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				cmd.store_in = in_fire && !sts.full;
			end
			ST_PAIR_INIT: cmd.pair_init = 1'b1;
			ST_RD_I: cmd.rd_i = 1'b1;
			ST_RD_J: cmd.rd_j = 1'b1;
			ST_SQUARE: begin
				cmd.square = 1'b1;
				cmd.sqrt_start = 1'b1;
			end
			ST_CHECK: cmd.next_pair = !sts.do_push;
			ST_PROD: begin
				cmd.prod = 1'b1;
				cmd.div_start = 1'b1;
			end
			ST_WB_I: cmd.wb_i = 1'b1;
			ST_WB_J: begin
				cmd.wb_j = 1'b1;
				cmd.next_pair = 1'b1;
			end
			ST_EMIT_RD: cmd.emit_rd = 1'b1;
			ST_EMIT: begin
				cmd.out_load = 1'b1;
				cmd.emit_next = 1'b1;
				cmd.clr_total = sts.emit_done;
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_LOAD) else $error("ready outside load");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_last |=> state_q == ST_PAIR_INIT) else $error("no pass start");
	a_wb: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WB_I |=> state_q == ST_WB_J) else $error("write back split");
`endif
endmodule
`default_nettype wire

[rtl/pcor_dp.sv]
`default_nettype none
module pcor_dp #(
	parameter int MAX_BALLS = pcor_pkg::MAX_BALLS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire pcor_pkg::cmd_t cmd,
	output pcor_pkg::sts_t sts,
	input  wire logic [15:0] factor,
	input  wire logic signed [23:0] in_x,
	input  wire logic signed [23:0] in_y,
	input  wire logic [15:0] in_r,
	input  wire logic out_fire,
	output logic out_valid,
	output logic signed [23:0] out_x,
	output logic signed [23:0] out_y,
	output logic out_last
);
	import pcor_pkg::*;
	localparam int IW = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;
	localparam int CW = $clog2(MAX_BALLS + 1);

	logic signed [POS_W-1:0] mem_x [MAX_BALLS];
	logic signed [POS_W-1:0] mem_y [MAX_BALLS];
	logic [RAD_W-1:0] mem_r [MAX_BALLS];
	logic [CW-1:0] total_q, i_q, j_q, e_q;
	logic signed [POS_W-1:0] rx_q, ry_q, xi_q, yi_q, xj_q, yj_q;
	logic [RAD_W-1:0] rr_q, ri_q;
	logic [IW-1:0] waddr, raddr;
	logic we;
	logic signed [POS_W-1:0] wx, wy;

	logic signed [POS_W:0] dx, dy;
	logic [POS_W-1:0] ax_q, ay_q;
	logic sx_q, sy_q;
	logic [SQ_W-1:0] sq_q;
	logic [RAD_W:0] rs_q;
	logic [SQ_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [4:0] scnt_q;
	logic sbusy_q;
	logic [NUM_W-1:0] nx_q, ny_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] qx_q, qy_q;
	logic [DEN_W:0] remx_q, remy_q;
	logic [6:0] dcnt_q;
	logic dbusy_q;
	logic [RAD_W:0] m;
	logic [RAD_W+FAC_W:0] mf_q;
	logic signed [POS_W+1:0] mx, my;

	assign dx = {xi_q[POS_W-1], xi_q} - {rx_q[POS_W-1], rx_q};
	assign dy = {yi_q[POS_W-1], yi_q} - {ry_q[POS_W-1], ry_q};

	function automatic logic signed [POS_W-1:0] sat(input logic signed [POS_W+1:0] v);
		if (v > $signed({{2{1'b0}}, 1'b0, {(POS_W-1){1'b1}}}))
			return {1'b0, {(POS_W-1){1'b1}}};
		else if (v < $signed({{2{1'b1}}, 1'b1, {(POS_W-1){1'b0}}}))
			return {1'b1, {(POS_W-1){1'b0}}};
		else return v[POS_W-1:0];
	endfunction

	function automatic logic signed [POS_W+1:0] mag_to_s(input logic [NUM_W-1:0] q,
			input logic neg);
		logic signed [POS_W+1:0] t;
		t = $signed({1'b0, q[POS_W:0]});
		return neg ? -t : t;
	endfunction

	assign mx = mag_to_s(qx_q, sx_q);
	assign my = mag_to_s(qy_q, sy_q);

	always_comb begin
		we = 1'b0;
		waddr = total_q[IW-1:0];
		wx = in_x;
		wy = in_y;
		if (cmd.store_in) we = 1'b1;
		else if (cmd.wb_i) begin
			we = 1'b1;
			waddr = i_q[IW-1:0];
			wx = sat({{2{xi_q[POS_W-1]}}, xi_q} + mx);
			wy = sat({{2{yi_q[POS_W-1]}}, yi_q} + my);
		end else if (cmd.wb_j) begin
			we = 1'b1;
			waddr = j_q[IW-1:0];
			wx = sat({{2{xj_q[POS_W-1]}}, xj_q} - mx);
			wy = sat({{2{yj_q[POS_W-1]}}, yj_q} - my);
		end
		raddr = cmd.emit_rd ? e_q[IW-1:0] : (cmd.rd_i ? i_q[IW-1:0] : j_q[IW-1:0]);
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_x[waddr] <= wx;
			mem_y[waddr] <= wy;
		end
		if (cmd.store_in) mem_r[waddr] <= in_r;
		rx_q <= mem_x[raddr];
		ry_q <= mem_y[raddr];
		rr_q <= mem_r[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			i_q <= '0;
			j_q <= '0;
			e_q <= '0;
			sbusy_q <= 1'b0;
			dbusy_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.store_in) total_q <= total_q + 1'b1;
			if (cmd.clr_total) total_q <= '0;
			if (cmd.pair_init) begin
				i_q <= '0;
				j_q <= CW'(1);
				e_q <= '0;
			end
			if (cmd.next_pair) begin
				if (CW'(j_q + 1'b1) >= total_q) begin
					i_q <= i_q + 1'b1;
					j_q <= i_q + CW'(2);
				end else j_q <= j_q + 1'b1;
			end
			if (cmd.emit_next) e_q <= e_q + 1'b1;
			if (cmd.sqrt_start) sbusy_q <= 1'b1;
			else if (sbusy_q && scnt_q == 5'd0) sbusy_q <= 1'b0;
			if (cmd.div_start) dbusy_q <= 1'b1;
			else if (dbusy_q && dcnt_q == 7'd0) dbusy_q <= 1'b0;
			if (cmd.out_load) out_valid <= 1'b1;
			else if (out_fire) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		mf_q <= m * factor;
		if (cmd.rd_j) begin
			xi_q <= rx_q;
			yi_q <= ry_q;
			ri_q <= rr_q;
		end
		if (cmd.square) begin
			xj_q <= rx_q;
			yj_q <= ry_q;
			ax_q <= dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
			ay_q <= dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
			sx_q <= dx[POS_W];
			sy_q <= dy[POS_W];
			rs_q <= {1'b0, ri_q} + {1'b0, rr_q};
		end
		if (cmd.sqrt_start) begin
			scnt_q <= 5'd26;
			root_q <= '0;
			rem_q <= '0;
		end else if (sbusy_q && scnt_q != 5'd0) begin
			if (scnt_q == 5'd26) begin
				sq_q <= SQ_W'(ax_q * ax_q) + SQ_W'(ay_q * ay_q);
				scnt_q <= 5'd25;
			end else begin
				logic [SQ_W+1:0] tr, tt;
				tr = {rem_q, sq_q[SQ_W-1 -: 2]};
				tt = {{(SQ_W-ROOT_W){1'b0}}, root_q, 2'b01};
				if (tr >= tt) begin
					rem_q <= SQ_W'(tr - tt);
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q <= SQ_W'(tr);
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
				sq_q <= {sq_q[SQ_W-3:0], 2'b00};
				scnt_q <= scnt_q - 1'b1;
			end
		end
		if (cmd.prod) begin
			nx_q <= NUM_W'(ax_q * mf_q);
			ny_q <= NUM_W'(ay_q * mf_q);
			den_q <= {root_q[ROOT_W-1:0], 16'd0};
		end
		if (cmd.div_start) begin
			dcnt_q <= 7'd66;
			remx_q <= '0;
			remy_q <= '0;
		end else if (dbusy_q && dcnt_q != 7'd0) begin
			logic [DEN_W:0] tx, ty;
			tx = {remx_q[DEN_W-1:0], nx_q[NUM_W-1]};
			ty = {remy_q[DEN_W-1:0], ny_q[NUM_W-1]};
			nx_q <= {nx_q[NUM_W-2:0], 1'b0};
			ny_q <= {ny_q[NUM_W-2:0], 1'b0};
			if (tx >= {1'b0, den_q}) begin
				remx_q <= tx - {1'b0, den_q};
				qx_q <= {qx_q[NUM_W-2:0], 1'b1};
			end else begin
				remx_q <= tx;
				qx_q <= {qx_q[NUM_W-2:0], 1'b0};
			end
			if (ty >= {1'b0, den_q}) begin
				remy_q <= ty - {1'b0, den_q};
				qy_q <= {qy_q[NUM_W-2:0], 1'b1};
			end else begin
				remy_q <= ty;
				qy_q <= {qy_q[NUM_W-2:0], 1'b0};
			end
			dcnt_q <= dcnt_q - 1'b1;
		end
		if (cmd.out_load) begin
			out_x <= rx_q;
			out_y <= ry_q;
			out_last <= CW'(e_q + 1'b1) == total_q;
		end
	end

	assign m = rs_q - (RAD_W+1)'(root_q);

	always_comb begin
		sts.full = total_q >= CW'(MAX_BALLS);
		sts.pair_done = cmd.pair_init ? (total_q <= CW'(1))
			: (CW'(i_q + 1'b1) >= total_q
			|| (cmd.next_pair && CW'(j_q + 1'b1) >= total_q
			&& CW'(i_q + CW'(2)) >= total_q));
		sts.sqrt_done = sbusy_q && scnt_q == 5'd0;
		sts.div_done = dbusy_q && dcnt_q == 7'd0;
		sts.do_push = root_q != '0 && {{(ROOT_W-RAD_W-1){1'b0}}, rs_q} > root_q;
		sts.emit_done = CW'(e_q + 1'b1) >= total_q;
	end

`ifndef SYNTHESIS
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(MAX_BALLS)) else $error("ball count overflow");
	a_ord: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wb_i |-> i_q < j_q) else $error("pair order");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(sbusy_q && dbusy_q)) else $error("units overlap");
`endif
endmodule
`default_nettype wire

[rtl/pairwise_circle_overlap_relax_core.sv]
`default_nettype none
// Circle overlap relaxation core.
// Balls arrive on in_ch, one per transfer; each is stored until the one
// marked last_ball, after which the core accepts nothing more until all
// results have left. It then runs one pass over all pairs i < j, reading
// both balls from the position memory, taking an iterative square root
// and, for overlapping pairs with distinct centres only, two parallel
// restoring divisions and writing both balls back.
// Results leave on out_ch, one per ball in input order, last_out on the
// final one; a stalled receiver simply holds the output register and
// pauses emission. Balls beyond MAX_BALLS are dropped. cfg_ch writes
// overlap_factor at any transfer. Reset empties the set and restores
// overlap_factor to one half; memory contents are kept.
module pairwise_circle_overlap_relax_core #(
	parameter int MAX_BALLS = pcor_pkg::MAX_BALLS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	pcor_in_if.sink in_ch,
	pcor_out_if.source out_ch,
	pcor_cfg_if.sink cfg_ch
);
	import pcor_pkg::*;
	cmd_t cmd;
	sts_t sts;
	logic [FAC_W-1:0] factor_q;
	logic in_fire, out_fire;

	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) factor_q <= FACTOR_RESET;
		else if (cfg_ch.valid) factor_q <= cfg_ch.data;
	end

	assign in_fire = in_ch.valid && in_ch.ready;
	assign out_fire = out_ch.valid && out_ch.ready;

	pcor_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_last(in_ch.last_ball),
		.out_fire(out_fire), .out_valid(out_ch.valid), .sts(sts), .cmd(cmd),
		.in_ready(in_ch.ready)
	);

	pcor_dp #(.MAX_BALLS(MAX_BALLS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .factor(factor_q),
		.in_x(in_ch.pos_x), .in_y(in_ch.pos_y), .in_r(in_ch.radius),
		.out_fire(out_fire), .out_valid(out_ch.valid), .out_x(out_ch.new_x),
		.out_y(out_ch.new_y), .out_last(out_ch.last_out)
	);
endmodule
`default_nettype wire
